// File: src/kvpd_pkg.sv
// Shared types and constants for the key/value packet stream deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package kvpd_pkg;

    // Header and body geometry
    localparam int unsigned HDR_LAST_IDX  = 6;
    localparam int unsigned CTRL_LAST_IDX = 3;

    // Output word layout in m_axis_tdata, lowest bit first
    localparam int unsigned TDATA_W = 152;
    localparam int unsigned TUSER_W = 4;

    // Register map
    localparam int unsigned PADDR_W  = 3;
    localparam logic        REG_CTRL_BIT = 1'b0;   // register index of control_flag_bit
    localparam logic [2:0]  CTRL_BIT_RESET = 3'd7;

    // Byte kind codes
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_KEY     = 3'd1;
    localparam logic [2:0] KIND_VALUE   = 3'd2;
    localparam logic [2:0] KIND_CTRL    = 3'd3;
    localparam logic [2:0] KIND_DISCARD = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_SHORT_HDR  = 2'd1;
    localparam logic [1:0] ERR_SHORT_BODY = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_KEY     = 5'b00010,
        PH_VALUE   = 5'b00100,
        PH_CTRL    = 5'b01000,
        PH_DISCARD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  byte_out;
        logic        header_done;
        logic        packet_done;
        logic [1:0]  error_code;
        logic [7:0]  flags_out;
        logic [15:0] key_length;
        logic [31:0] value_length;
        logic [15:0] hash_ident;
        logic [15:0] node_ident;
        logic [31:0] node_address;
        logic [15:0] node_port_out;
    } t_result;

endpackage

`default_nettype wire

// File: src/kvpd_regs.sv
// Configuration register file behind the APB-style port.
// Depends on kvpd_pkg for the register map and reset value.
`default_nettype none

module kvpd_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kvpd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [2:0]                       o_ctrl_bit
);

    logic [2:0] r_ctrl_bit;
    logic       reg_sel;
    logic       wr_en;

    // Decode the word index and the write strobe
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == kvpd_pkg::REG_CTRL_BIT);
    assign wr_en   = psel && penable && pwrite && pready && reg_sel;

    // Hold the control flag bit position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_bit <= kvpd_pkg::CTRL_BIT_RESET;
        end else if (wr_en) begin
            r_ctrl_bit <= pwdata[2:0];
        end
    end

    // Read back the register, zero elsewhere
    assign prdata     = reg_sel ? {29'd0, r_ctrl_bit} : 32'd0;
    assign o_ctrl_bit = r_ctrl_bit;

endmodule

`default_nettype wire

// File: src/kvpd_decode.sv
// Packet state and the single-pass decode of one byte into a result word.
// Depends on kvpd_pkg for the phase enum, codes and the result struct.
`default_nettype none

module kvpd_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    input  wire logic [2:0]        i_ctrl_bit,
    output kvpd_pkg::t_result      o_result
);

    kvpd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_hidx, n_hidx;
    logic [15:0] r_key, n_key;
    logic [31:0] r_val, n_val;
    logic [1:0]  r_bidx, n_bidx;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_fa, n_fa;
    logic [31:0] r_fb, n_fb;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_port, n_port;

    logic        is_ctrl;
    logic        complete;
    logic [2:0]  kind;
    logic        hdone;
    logic [1:0]  err;

    // Flags of the current packet, including a flags byte arriving now
    assign n_flags = (r_phase == kvpd_pkg::PH_HEADER && r_hidx == 3'd0) ? i_byte : r_flags;
    assign is_ctrl = n_flags[i_ctrl_bit];

    // Decode one byte and compute the next packet state
    always_comb begin
        n_phase  = r_phase;
        n_hidx   = r_hidx;
        n_key    = r_key;
        n_val    = r_val;
        n_bidx   = r_bidx;
        n_fa     = r_fa;
        n_fb     = r_fb;
        n_addr   = r_addr;
        n_port   = r_port;
        kind     = kvpd_pkg::KIND_DISCARD;
        hdone    = 1'b0;
        complete = 1'b0;
        err      = kvpd_pkg::ERR_NONE;

        unique case (r_phase)
            kvpd_pkg::PH_HEADER: begin
                kind = kvpd_pkg::KIND_HEADER;
                // Shift the byte into the field it belongs to
                if (r_hidx == 3'd0) begin
                    n_fa   = '0;
                    n_fb   = '0;
                    n_addr = '0;
                    n_port = '0;
                end else if (r_hidx <= 3'd2) begin
                    n_fa = {r_fa[7:0], i_byte};
                end else if (is_ctrl) begin
                    if (r_hidx <= 3'd4) begin
                        n_fb = {16'd0, r_fb[7:0], i_byte};
                    end else begin
                        n_addr = {r_addr[23:16], r_addr[15:8] | i_byte, 16'd0};
                    end
                end else begin
                    n_fb = {r_fb[23:0], i_byte};
                end
                // Close the header and pick the body phase
                if (r_hidx >= 3'(kvpd_pkg::HDR_LAST_IDX)) begin
                    hdone  = 1'b1;
                    n_hidx = '0;
                    n_bidx = '0;
                    if (is_ctrl) begin
                        n_phase = kvpd_pkg::PH_CTRL;
                    end else begin
                        n_key = n_fa;
                        n_val = n_fb;
                        if (n_fa != 16'd0) begin
                            n_phase = kvpd_pkg::PH_KEY;
                        end else if (n_fb != 32'd0) begin
                            n_phase = kvpd_pkg::PH_VALUE;
                        end else begin
                            complete = 1'b1;
                        end
                    end
                    if (i_last && !complete) begin
                        err = kvpd_pkg::ERR_SHORT_BODY;
                    end
                end else begin
                    n_hidx = r_hidx + 3'd1;
                    if (i_last) begin
                        err = kvpd_pkg::ERR_SHORT_HDR;
                    end
                end
            end
            kvpd_pkg::PH_KEY: begin
                kind  = kvpd_pkg::KIND_KEY;
                n_key = r_key - 16'd1;
                if (n_key == 16'd0) begin
                    if (r_val == 32'd0) begin
                        complete = 1'b1;
                    end else begin
                        n_phase = kvpd_pkg::PH_VALUE;
                    end
                end
                if (i_last && !complete) begin
                    err = kvpd_pkg::ERR_SHORT_BODY;
                end
            end
            kvpd_pkg::PH_VALUE: begin
                kind  = kvpd_pkg::KIND_VALUE;
                n_val = r_val - 32'd1;
                if (n_val == 32'd0) begin
                    complete = 1'b1;
                end
                if (i_last && !complete) begin
                    err = kvpd_pkg::ERR_SHORT_BODY;
                end
            end
            kvpd_pkg::PH_CTRL: begin
                kind = kvpd_pkg::KIND_CTRL;
                // Lower address half first, then the port
                if (r_bidx <= 2'd1) begin
                    n_addr = {r_addr[31:16], r_addr[7:0], i_byte};
                end else begin
                    n_port = {r_port[7:0], i_byte};
                end
                if (r_bidx == 2'(kvpd_pkg::CTRL_LAST_IDX)) begin
                    n_bidx   = '0;
                    complete = 1'b1;
                end else begin
                    n_bidx = r_bidx + 2'd1;
                end
                if (i_last && !complete) begin
                    err = kvpd_pkg::ERR_SHORT_BODY;
                end
            end
            kvpd_pkg::PH_DISCARD: begin
                kind = kvpd_pkg::KIND_DISCARD;
            end
            default: begin
                kind = kvpd_pkg::KIND_DISCARD;
            end
        endcase

        // Drop trailing bytes after a finished packet
        if (complete) begin
            n_phase = kvpd_pkg::PH_DISCARD;
        end

        // Rearm for the next buffer
        if (i_last) begin
            n_phase = kvpd_pkg::PH_HEADER;
            n_hidx  = '0;
            n_bidx  = '0;
            n_key   = '0;
            n_val   = '0;
        end
    end

    // Assemble the result word; decoded fields only on packet completion
    always_comb begin
        o_result               = '0;
        o_result.byte_kind     = kind;
        o_result.byte_out      = i_byte;
        o_result.header_done   = hdone;
        o_result.packet_done   = complete;
        o_result.error_code    = err;
        o_result.flags_out     = n_flags;
        if (complete) begin
            if (is_ctrl) begin
                o_result.hash_ident    = n_fa;
                o_result.node_ident    = n_fb[15:0];
                o_result.node_address  = n_addr;
                o_result.node_port_out = n_port;
            end else begin
                o_result.key_length   = n_fa;
                o_result.value_length = n_fb;
            end
        end
    end

    // Advance the packet state once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kvpd_pkg::PH_HEADER;
            r_hidx  <= '0;
            r_key   <= '0;
            r_val   <= '0;
            r_bidx  <= '0;
            r_flags <= '0;
            r_fa    <= '0;
            r_fb    <= '0;
            r_addr  <= '0;
            r_port  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_key   <= n_key;
            r_val   <= n_val;
            r_bidx  <= n_bidx;
            r_flags <= n_flags;
            r_fa    <= n_fa;
            r_fb    <= n_fb;
            r_addr  <= n_addr;
            r_port  <= n_port;
        end
    end

endmodule

`default_nettype wire

// File: src/kv_packet_stream_deframer.sv
// Path: a word accepted into the input register is decoded into the result register.
// Throughput: one byte per cycle while m_axis_tready is high; the decode is a single
// pass between the input register and the result register, and both drain together.
// Reset (synchronous, active low) empties both registers, returns the
// deframer to the header phase and sets control_flag_bit to 7.
// Top level: stream deframer with APB config; uses kvpd_pkg, kvpd_regs, kvpd_decode.
`default_nettype none

module kv_packet_stream_deframer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB-style configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kvpd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input byte stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  wire logic                         s_axis_tlast,   // buffer_end
    // Tagged result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [7:0] byte_out, [9:8] error_code, [17:10] flags_out, [33:18] key_length,
    // [65:34] value_length, [81:66] hash_ident, [97:82] node_ident,
    // [129:98] node_address, [145:130] node_port_out, [151:146] zero
    output logic [kvpd_pkg::TDATA_W-1:0]      m_axis_tdata,
    // [2:0] byte_kind, [3] header_done
    output logic [kvpd_pkg::TUSER_W-1:0]      m_axis_tuser,
    output logic                              m_axis_tlast    // packet_done
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    kvpd_pkg::t_result r_out;
    kvpd_pkg::t_result result;
    logic              advance;
    logic [2:0]        ctrl_bit;

    kvpd_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_ctrl_bit (ctrl_bit)
    );

    kvpd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_ctrl_bit (ctrl_bit),
        .o_result   (result)
    );

    // Move the held word into the result register when that slot frees up
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    // Pack the result word onto the output stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.packet_done;
    assign m_axis_tuser  = {r_out.header_done, r_out.byte_kind};
    assign m_axis_tdata  = {6'd0,
                            r_out.node_port_out,
                            r_out.node_address,
                            r_out.node_ident,
                            r_out.hash_ident,
                            r_out.value_length,
                            r_out.key_length,
                            r_out.flags_out,
                            r_out.error_code,
                            r_out.byte_out};

endmodule

`default_nettype wire
